// ===== design/trce_pkg.sv =====
// Shared types and constants for the two-register CPU executor.
// No dependencies; trce_exec and the top level import this package.
package trce_pkg;

    localparam int DATA_W            = 16;
    localparam int PC_W              = 15;
    localparam int RAM_ADDR_BITS_DEF = 15;

    // Instruction word bit positions
    localparam int BIT_COMPUTE = 15;
    localparam int BIT_Y_MEM   = 12;
    localparam int BIT_ZX      = 11;
    localparam int BIT_NX      = 10;
    localparam int BIT_ZY      = 9;
    localparam int BIT_NY      = 8;
    localparam int BIT_F       = 7;
    localparam int BIT_NO      = 6;
    localparam int BIT_DEST_A  = 5;
    localparam int BIT_DEST_D  = 4;
    localparam int BIT_DEST_M  = 3;
    localparam int BIT_JLT     = 2;
    localparam int BIT_JEQ     = 1;
    localparam int BIT_JGT     = 0;

    typedef struct packed {
        logic [DATA_W-1:0] alu_result;
        logic              zero_flag;
        logic              negative_flag;
        logic              jump_taken;
        logic [PC_W-1:0]   next_pc;
        logic              mem_write;
        logic [DATA_W-1:0] a_value;
        logic [DATA_W-1:0] d_value;
    } trce_exec_t;

endpackage

// ===== design/trce_if.sv =====
// Valid/ready channel interfaces for instructions and execution results.
// Depends on nothing; widths follow the instruction format.
interface trce_instr_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface trce_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] alu_result;
    logic               zero_flag;
    logic               negative_flag;
    logic               jump_taken;
    logic        [14:0] next_pc;
    logic               mem_write;
    logic        [14:0] mem_address;
    logic signed [15:0] a_value;
    logic signed [15:0] d_value;

    modport source (output valid, output alu_result, output zero_flag,
                    output negative_flag, output jump_taken, output next_pc,
                    output mem_write, output mem_address, output a_value,
                    output d_value, input ready);
    modport sink   (input valid, input alu_result, input zero_flag,
                    input negative_flag, input jump_taken, input next_pc,
                    input mem_write, input mem_address, input a_value,
                    input d_value, output ready);
endinterface

// ===== design/trce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/trce_exec.sv =====
// Combinational execute stage: ALU, destination select, jump decision.
// Depends on trce_pkg.
module trce_exec (
    input  logic [trce_pkg::DATA_W-1:0] instruction,
    input  logic [trce_pkg::DATA_W-1:0] a,
    input  logic [trce_pkg::DATA_W-1:0] d,
    input  logic [trce_pkg::PC_W-1:0]   pc,
    input  logic [trce_pkg::DATA_W-1:0] y_mem,
    output trce_pkg::trce_exec_t        res
);
    import trce_pkg::*;

    logic [DATA_W-1:0] x0, x1, y0, y1, y2, f_out, r;
    logic [PC_W-1:0]   pc_inc;
    logic              zr, ng, jmp;

    always_comb
    begin
        y0     = instruction[BIT_Y_MEM] ? y_mem : a;
        x0     = instruction[BIT_ZX] ? '0 : d;
        x1     = instruction[BIT_NX] ? ~x0 : x0;
        y1     = instruction[BIT_ZY] ? '0 : y0;
        y2     = instruction[BIT_NY] ? ~y1 : y1;
        f_out  = instruction[BIT_F] ? (x1 + y2) : (x1 & y2);
        r      = instruction[BIT_NO] ? ~f_out : f_out;
        zr     = (r == '0);
        ng     = r[DATA_W-1];
        jmp    = (instruction[BIT_JLT] && ng) || (instruction[BIT_JEQ] && zr)
                 || (instruction[BIT_JGT] && !zr && !ng);
        pc_inc = pc + PC_W'(1);

        if (!instruction[BIT_COMPUTE])
        begin
            // load immediate into A
            res.alu_result    = '0;
            res.zero_flag     = 1'b0;
            res.negative_flag = 1'b0;
            res.jump_taken    = 1'b0;
            res.next_pc       = pc_inc;
            res.mem_write     = 1'b0;
            res.a_value       = {1'b0, instruction[PC_W-1:0]};
            res.d_value       = d;
        end
        else
        begin
            res.alu_result    = r;
            res.zero_flag     = zr;
            res.negative_flag = ng;
            res.jump_taken    = jmp;
            res.next_pc       = jmp ? a[PC_W-1:0] : pc_inc;
            res.mem_write     = instruction[BIT_DEST_M];
            res.a_value       = instruction[BIT_DEST_A] ? r : a;
            res.d_value       = instruction[BIT_DEST_D] ? r : d;
        end
    end

endmodule

// ===== design/two_register_cpu_executor.sv =====
// Top level of the two-register CPU executor: channels, state, data RAM.
// Depends on trce_pkg, trce_if, trce_ram and trce_exec.
//
//  Channel   Dir   Handshake      Payload
//  instr     in    valid/ready    instruction[15:0]
//  result    out   valid/ready    alu_result, flags, next_pc, mem_write,
//                                 mem_address, a_value, d_value
//
// Throughput is one instruction per cycle while result.ready is high and no clearing
// pass runs; result.valid rises after the instruction register, then the result register.
// The RAM read port is always addressed by A as it will be once the executing
// instruction retires, so RAM[A] is ready when the next instruction executes.
// After reset a clearing pass writes zero to every RAM word, with instr.ready held
// low. A stalled result holds the instruction register; a new instruction is still
// taken while the result register drains.
module two_register_cpu_executor #(
    parameter int RAM_ADDR_BITS = trce_pkg::RAM_ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    trce_instr_if.sink    instr,
    trce_result_if.source result
);
    import trce_pkg::*;

    localparam int RAM_WORDS = 1 << RAM_ADDR_BITS;

    // Clearing pass
    logic                     clr_busy_reg, clr_busy_next;
    logic [RAM_ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;

    // Instruction register
    logic              ins_valid_reg, ins_valid_next;
    logic [DATA_W-1:0] ins_reg, ins_next;

    // Architectural state
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [PC_W-1:0]   pc_reg, pc_next;

    // Result register
    logic              res_valid_reg, res_valid_next;
    trce_exec_t        res_reg, res_next;
    logic [PC_W-1:0]   maddr_reg, maddr_next;

    // RAM and write-to-read bypass
    logic                     ram_we;
    logic [RAM_ADDR_BITS-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0]        ram_wdata, ram_rdata;
    logic                     fwd_hit_reg, fwd_hit_next;
    logic [DATA_W-1:0]        fwd_data_reg, fwd_data_next;
    logic [DATA_W-1:0]        y_mem;

    trce_exec_t exec_res;
    logic       advance;
    logic       in_take;

    trce_exec u_exec (
        .instruction (ins_reg),
        .a           (a_reg),
        .d           (d_reg),
        .pc          (pc_reg),
        .y_mem       (y_mem),
        .res         (exec_res)
    );

    trce_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake: the executing instruction retires when the result slot frees.
    assign advance     = ins_valid_reg && (!res_valid_reg || result.ready);
    assign instr.ready = !clr_busy_reg && (!ins_valid_reg || advance);
    assign in_take     = instr.valid && instr.ready;

    // A freshly written word is not yet visible on the registered read port.
    assign y_mem = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + RAM_ADDR_BITS'(1);
            if (clr_addr_reg == '1)
            begin
                clr_busy_next = 1'b0;
            end
        end

        ins_valid_next = in_take || (ins_valid_reg && !advance);
        ins_next       = in_take ? instr.instruction : ins_reg;

        a_next  = advance ? exec_res.a_value : a_reg;
        d_next  = advance ? exec_res.d_value : d_reg;
        pc_next = advance ? exec_res.next_pc : pc_reg;

        // RAM write uses A from before the instruction
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = advance && exec_res.mem_write;
            ram_waddr = a_reg[RAM_ADDR_BITS-1:0];
            ram_wdata = exec_res.alu_result;
        end
        ram_raddr = a_next[RAM_ADDR_BITS-1:0];

        fwd_hit_next  = ram_we && (ram_waddr == ram_raddr);
        fwd_data_next = ram_wdata;

        res_valid_next = advance || (res_valid_reg && !result.ready);
        res_next       = advance ? exec_res : res_reg;
        if (advance)
        begin
            maddr_next = ins_reg[BIT_COMPUTE] ? PC_W'(a_reg[RAM_ADDR_BITS-1:0]) : '0;
        end
        else
        begin
            maddr_next = maddr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            ins_valid_reg <= 1'b0;
            a_reg         <= '0;
            d_reg         <= '0;
            pc_reg        <= '0;
            res_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            ins_valid_reg <= ins_valid_next;
            a_reg         <= a_next;
            d_reg         <= d_next;
            pc_reg        <= pc_next;
            res_valid_reg <= res_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        ins_reg      <= ins_next;
        res_reg      <= res_next;
        maddr_reg    <= maddr_next;
        fwd_data_reg <= fwd_data_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.alu_result    = res_reg.alu_result;
    assign result.zero_flag     = res_reg.zero_flag;
    assign result.negative_flag = res_reg.negative_flag;
    assign result.jump_taken    = res_reg.jump_taken;
    assign result.next_pc       = res_reg.next_pc;
    assign result.mem_write     = res_reg.mem_write;
    assign result.mem_address   = maddr_reg;
    assign result.a_value       = res_reg.a_value;
    assign result.d_value       = res_reg.d_value;

    // No instruction may enter while the RAM is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !ins_valid_reg && !res_valid_reg)
        else $error("instruction in flight during RAM clearing pass");

    // A retiring instruction always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result.valid)
        else $error("retired instruction lost");

    // Only compute instructions write the RAM
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && exec_res.mem_write) |-> ins_reg[BIT_COMPUTE])
        else $error("RAM write from load-immediate");

    // Without a jump the program counter steps by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !exec_res.jump_taken) |=> pc_reg == $past(pc_reg) + PC_W'(1))
        else $error("program counter did not increment");

    // A set zero flag comes with a zero ALU value (loads report a zero ALU value and a clear zero flag)
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_flag) |-> result.alu_result == 16'sd0)
        else $error("zero flag inconsistent with ALU result");

endmodule
